/* rtl/pid_position_delta_controller_macros.svh */
// Assertion macros for the PID position/delta controller checker.
// Included by files that assert; no other dependencies.
`ifndef PID_POSITION_DELTA_CONTROLLER_MACROS_SVH
`define PID_POSITION_DELTA_CONTROLLER_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/pdc_pkg.sv */
// Shared constants, codes and types of the PID position/delta controller.
// No dependencies.
package pdc_pkg;

    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int GAIN_W             = 16;
    localparam int LIMIT_W            = 15;
    localparam int SUM_W              = 32;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_KP_GAIN  = 3'd1,
        REG_KI_GAIN  = 3'd2,
        REG_KD_GAIN  = 3'd3,
        REG_MAX_OUT  = 3'd4,
        REG_MAX_IOUT = 3'd5
    } cfg_reg_t;

    localparam logic MODE_POSITION  = 1'b0;
    localparam logic MODE_DELTA     = 1'b1;
    localparam logic KIND_STEP      = 1'b0;
    localparam logic KIND_CLEAR     = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        logic                      mode;
        logic signed [GAIN_W-1:0]  kp_gain;
        logic signed [GAIN_W-1:0]  ki_gain;
        logic signed [GAIN_W-1:0]  kd_gain;
        logic [LIMIT_W-1:0]        max_out;
        logic [LIMIT_W-1:0]        max_iout;
    } pdc_cfg_t;

endpackage

/* rtl/pdc_if.sv */
// Request and response channel interfaces of the PID controller.
// Depends on pdc_pkg.
interface pdc_req_if #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;

    modport source (output valid, output kind, output target, output measured, input ready);
    modport sink   (input valid, input kind, input target, input measured, output ready);
endinterface

interface pdc_rsp_if #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

/* rtl/pdc_cfg_regs.sv */
// Configuration register file of the PID controller: mode, gains, limits.
// Depends on pdc_pkg.
module pdc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pdc_pkg::pdc_cfg_t               cfg
);
    import pdc_pkg::*;

    pdc_cfg_t cfg_reg;
    pdc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     cfg_next.mode     = cfg_data[0];
                REG_KP_GAIN:  cfg_next.kp_gain  = $signed(cfg_data[GAIN_W-1:0]);
                REG_KI_GAIN:  cfg_next.ki_gain  = $signed(cfg_data[GAIN_W-1:0]);
                REG_KD_GAIN:  cfg_next.kd_gain  = $signed(cfg_data[GAIN_W-1:0]);
                REG_MAX_OUT:  cfg_next.max_out  = cfg_data[LIMIT_W-1:0];
                REG_MAX_IOUT: cfg_next.max_iout = cfg_data[LIMIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= MODE_POSITION;
            cfg_reg.kp_gain  <= '0;
            cfg_reg.ki_gain  <= '0;
            cfg_reg.kd_gain  <= '0;
            cfg_reg.max_out  <= LIMIT_RESET;
            cfg_reg.max_iout <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pdc_datapath.sv */
// PID compute stage: error history, saturating error sum, three gain
// products, limits and the held output. Depends on pdc_pkg.
module pdc_datapath #(
    parameter int DATA_WIDTH     = pdc_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pdc_pkg::pdc_cfg_t            cfg,
    input  logic                         fire,
    input  logic                         kind,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic signed [DATA_WIDTH-1:0] measured,
    output logic signed [DATA_WIDTH-1:0] drive
);
    import pdc_pkg::*;

    localparam int EW    = DATA_WIDTH + 1;
    localparam int D1W   = DATA_WIDTH + 2;
    localparam int D2W   = DATA_WIDTH + 3;
    localparam int PPW   = GAIN_W + D1W;
    localparam int PIW   = GAIN_W + SUM_W;
    localparam int PDW   = GAIN_W + D2W;
    localparam int ACC_W = GAIN_W + DATA_WIDTH + 6;

    localparam logic signed [ACC_W-1:0] WMAX =
        ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(64'sd1 <<< (SUM_W - 1));

    logic signed [EW-1:0]    err_last_reg, err_before_reg;
    logic signed [SUM_W-1:0] err_sum_reg;
    logic signed [DATA_WIDTH-1:0] out_hold_reg;

    logic signed [EW-1:0]    err;
    logic signed [D1W-1:0]   diff1;
    logic signed [D2W-1:0]   diff2;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    pos_mode;

    logic signed [D1W-1:0]   op_p;
    logic signed [SUM_W-1:0] op_i;
    logic signed [D2W-1:0]   op_d;
    logic signed [PPW-1:0]   prod_p, sh_p;
    logic signed [PIW-1:0]   prod_i, sh_i, lim_i, term_i;
    logic signed [PDW-1:0]   prod_d, sh_d;

    logic signed [ACC_W-1:0] base, acc, lim_ext, lim, res;

    assign pos_mode = (cfg.mode == MODE_POSITION);

    assign err   = EW'(target) - EW'(measured);
    assign diff1 = D1W'(err) - D1W'(err_last_reg);
    assign diff2 = D2W'(err) - (D2W'(err_last_reg) <<< 1) + D2W'(err_before_reg);

    // error sum, saturated to the signed 32-bit range
    assign sum_wide = (SUM_W+1)'(err_sum_reg) + (SUM_W+1)'(err);
    always_comb
    begin
        if (sum_wide > SUM_MAX)
            sum_sat = SUM_W'(SUM_MAX);
        else if (sum_wide < SUM_MIN)
            sum_sat = SUM_W'(SUM_MIN);
        else
            sum_sat = SUM_W'(sum_wide);
    end

    assign op_p = pos_mode ? D1W'(err)   : diff1;
    assign op_i = pos_mode ? sum_sat     : SUM_W'(err);
    assign op_d = pos_mode ? D2W'(diff1) : diff2;

    assign prod_p = PPW'(cfg.kp_gain) * PPW'(op_p);
    assign prod_i = PIW'(cfg.ki_gain) * PIW'(op_i);
    assign prod_d = PDW'(cfg.kd_gain) * PDW'(op_d);

    assign sh_p = prod_p >>> GAIN_FRAC_BITS;
    assign sh_i = prod_i >>> GAIN_FRAC_BITS;
    assign sh_d = prod_d >>> GAIN_FRAC_BITS;

    // integral clamp applies in positional mode only
    assign lim_i = PIW'($signed({1'b0, cfg.max_iout}));
    always_comb
    begin
        if (pos_mode && (sh_i > lim_i))
            term_i = lim_i;
        else if (pos_mode && (sh_i < -lim_i))
            term_i = -lim_i;
        else
            term_i = sh_i;
    end

    assign base = pos_mode ? '0 : ACC_W'(out_hold_reg);
    assign acc  = base + ACC_W'(sh_p) + ACC_W'(term_i) + ACC_W'(sh_d);

    assign lim_ext = ACC_W'($signed({1'b0, cfg.max_out}));
    assign lim     = (lim_ext > WMAX) ? WMAX : lim_ext;

    always_comb
    begin
        if (acc > lim)
            res = lim;
        else if (acc < -lim)
            res = -lim;
        else
            res = acc;
    end

    assign drive = (kind == KIND_CLEAR) ? '0 : DATA_WIDTH'(res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_last_reg   <= '0;
            err_before_reg <= '0;
            err_sum_reg    <= '0;
            out_hold_reg   <= '0;
        end
        else if (fire)
        begin
            if (kind == KIND_CLEAR)
            begin
                err_last_reg   <= '0;
                err_before_reg <= '0;
                err_sum_reg    <= '0;
                out_hold_reg   <= '0;
            end
            else
            begin
                err_before_reg <= err_last_reg;
                err_last_reg   <= err;
                if (pos_mode)
                    err_sum_reg <= sum_sat;
                out_hold_reg   <= drive;
            end
        end
    end

endmodule

/* rtl/pid_position_delta_controller.sv */
// PID position/delta controller top level: request register, compute stage,
// response register. Depends on pdc_pkg, pdc_if, pdc_cfg_regs, pdc_datapath.
//
// Usage:
//   req carries kind (step or clear), target and measured; rsp carries drive.
//   Both are valid/ready channels; a request is taken when valid and ready
//   are high at a rising clock edge.
//   Configuration is a write-only port (cfg_we, cfg_index, cfg_data),
//   written while no request is in flight.
//   A request passes through the request register, then the combinational
//   compute into the response register, whose valid bit drives rsp.valid.
//   Throughput: one request per cycle while rsp.ready stays high; the error
//   history, error sum and held output feed back as each request fires.
//   A stalled response holds its drive; one more request waits in the
//   request register, after which req.ready drops until rsp.ready returns.
//   Reset clears both stages, the controller state and the registers
//   (gains 0, positional mode, limits 32767).
module pid_position_delta_controller #(
    parameter int DATA_WIDTH     = pdc_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pdc_req_if.sink                         req,
    pdc_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pdc_pkg::*;

    pdc_cfg_t cfg;

    logic                         a_valid_reg, a_valid_next;
    logic                         a_kind_reg;
    logic signed [DATA_WIDTH-1:0] a_target_reg, a_measured_reg;
    logic                         b_valid_reg, b_valid_next;
    logic signed [DATA_WIDTH-1:0] b_drive_reg;
    logic signed [DATA_WIDTH-1:0] drive_calc;
    logic                         fire, take;

    assign fire      = a_valid_reg && (!b_valid_reg || rsp.ready);
    assign req.ready = !a_valid_reg || fire;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (take)
            a_valid_next = 1'b1;
        else if (fire)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        if (fire)
            b_valid_next = 1'b1;
        else if (rsp.ready)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_kind_reg     <= req.kind;
            a_target_reg   <= req.target;
            a_measured_reg <= req.measured;
        end
        if (fire)
            b_drive_reg <= drive_calc;
    end

    pdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .fire     (fire),
        .kind     (a_kind_reg),
        .target   (a_target_reg),
        .measured (a_measured_reg),
        .drive    (drive_calc)
    );

    assign rsp.valid = b_valid_reg;
    assign rsp.drive = b_drive_reg;

endmodule

/* rtl/pdc_checker.sv */
// Port-level checks of the PID controller, bound to the top level.
// Depends on pdc_pkg and pid_position_delta_controller_macros.svh.
`include "pid_position_delta_controller_macros.svh"

module pdc_checker #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [DATA_WIDTH-1:0] drive
);

    `PDC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `PDC_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(drive), "drive changed while stalled")
    `PDC_ASSERT_SAME(a_drive_sym, clk, rst_n, rsp_valid, drive != {1'b1, {(DATA_WIDTH-1){1'b0}}}, "drive outside symmetric range")
    `PDC_ASSERT_SAME(a_rsp_cause, clk, rst_n, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without request two cycles earlier")

endmodule

bind pid_position_delta_controller pdc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .drive     (rsp.drive)
);

/* test/tb_pid_position_delta_controller.sv */
// Testbench for pid_position_delta_controller: positional and incremental PID
// steps, clears, output and integral limits, back-pressure, predicted per request.
// Depends on pdc_pkg, pdc_if and the controller RTL.
module tb_pid_position_delta_controller;
    import pdc_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_TAIL = 8;
    localparam int RAND_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint SUM_HI = 2147483647;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef logic signed [DW-1:0] sample_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pdc_req_if #(.DATA_WIDTH(DW)) req_ch ();
    pdc_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

    pid_position_delta_controller #(
        .DATA_WIDTH     (DW),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller image: registers and state
    logic cfg_mode = MODE_POSITION;
    logic signed [GAIN_W-1:0] cfg_kp = '0;
    logic signed [GAIN_W-1:0] cfg_ki = '0;
    logic signed [GAIN_W-1:0] cfg_kd = '0;
    logic [LIMIT_W-1:0] cfg_max_out = LIMIT_RESET;
    logic [LIMIT_W-1:0] cfg_max_iout = LIMIT_RESET;
    logic signed [DW:0] err_last = '0;
    logic signed [DW:0] err_before_last = '0;
    logic signed [SUM_W-1:0] err_sum = '0;
    sample_t out_hold = '0;

    sample_t pending_drive_q[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_off_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint limit_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic sample_t predict_drive(input logic step_kind, input sample_t tgt,
                                              input sample_t meas);
        longint err, prev, prev2, kp, ki, kd, sum, p_term, i_term, d_term, drive;
        if (step_kind == KIND_CLEAR)
        begin
            err_last = '0;
            err_before_last = '0;
            err_sum = '0;
            out_hold = '0;
            return '0;
        end
        err = longint'(tgt) - longint'(meas);
        prev = err_last;
        prev2 = err_before_last;
        kp = cfg_kp;
        ki = cfg_ki;
        kd = cfg_kd;
        if (cfg_mode == MODE_POSITION)
        begin
            sum = err_sum + err;
            if (sum > SUM_HI)
                sum = SUM_HI;
            else if (sum < SUM_LO)
                sum = SUM_LO;
            err_sum = sum[SUM_W-1:0];
            p_term = (kp * err) >>> GAIN_FRAC_BITS_DEF;
            i_term = limit_mag((ki * sum) >>> GAIN_FRAC_BITS_DEF, longint'(cfg_max_iout));
            d_term = (kd * (err - prev)) >>> GAIN_FRAC_BITS_DEF;
            drive = limit_mag(p_term + i_term + d_term, longint'(cfg_max_out));
        end
        else
        begin
            p_term = (kp * (err - prev)) >>> GAIN_FRAC_BITS_DEF;
            i_term = (ki * err) >>> GAIN_FRAC_BITS_DEF;
            d_term = (kd * (err - 2 * prev + prev2)) >>> GAIN_FRAC_BITS_DEF;
            drive = limit_mag(longint'(out_hold) + p_term + i_term + d_term,
                              longint'(cfg_max_out));
        end
        err_before_last = err_last;
        err_last = err[DW:0];
        out_hold = drive[DW-1:0];
        return drive[DW-1:0];
    endfunction

    function automatic void note_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:     cfg_mode = data[0];
            REG_KP_GAIN:  cfg_kp = data;
            REG_KI_GAIN:  cfg_ki = data;
            REG_KD_GAIN:  cfg_kd = data;
            REG_MAX_OUT:  cfg_max_out = data[LIMIT_W-1:0];
            REG_MAX_IOUT: cfg_max_iout = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return sample_t'($urandom);
            default: return sample_t'($urandom_range(0, 600) - 300);
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return GAIN_W'($urandom_range(0, 1024) - 512);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return LIMIT_RESET;
            2, 3: return LIMIT_W'($urandom_range(0, 3000));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    // response checker
    always @(posedge clk)
    begin : drive_check
        sample_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_drive_q.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual drive %0d",
                         $time, rsp_ch.drive);
                fail_count++;
            end
            else
            begin
                want = pending_drive_q.pop_front();
                if (rsp_ch.drive !== want)
                begin
                    $display("%0t: drive mismatch, expected %0d, actual %0d",
                             $time, want, rsp_ch.drive);
                    fail_count++;
                end
            end
        end
    end

    // response side: long hold-off on demand, otherwise random stall bursts while sink_gaps is set
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic step_kind, input sample_t tgt, input sample_t meas);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= step_kind;
        req_ch.target <= tgt;
        req_ch.measured <= meas;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_drive_q.push_back(predict_drive(step_kind, tgt, meas));
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        note_cfg_write(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic md, input logic signed [GAIN_W-1:0] kp,
                                  input logic signed [GAIN_W-1:0] ki,
                                  input logic signed [GAIN_W-1:0] kd,
                                  input logic [LIMIT_W-1:0] mo, input logic [LIMIT_W-1:0] mi);
        logic [CFG_DATA_W-2:0] junk;
        logic junk_top;
        junk = (CFG_DATA_W-1)'($urandom);
        junk_top = 1'($urandom);
        cfg_write(REG_MODE, {junk, md});
        cfg_write(REG_KP_GAIN, kp);
        cfg_write(REG_KI_GAIN, ki);
        cfg_write(REG_KD_GAIN, kd);
        cfg_write(REG_MAX_OUT, {junk_top, mo});
        junk_top = 1'($urandom);
        cfg_write(REG_MAX_IOUT, {junk_top, mi});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_request(KIND_STEP, 16'sd1000, -16'sd1000);
        send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        send_request(KIND_CLEAR, 16'sh7FFF, 16'sh7FFF);
    endtask

    task automatic test_position_directed();
        wait_for_drain();
        apply_settings(MODE_POSITION, 16'sh0100, 16'sh0040, 16'sh0080, 15'd20000, 15'd500);
        send_request(KIND_STEP, 16'sd0, 16'sd0);
        send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_STEP, 16'sd100, 16'sd50);
        send_request(KIND_STEP, -16'sd5, 16'sd3);
        send_request(KIND_CLEAR, 16'sd9, 16'sd1);
        send_request(KIND_STEP, 16'sd1, 16'sd0);
        // zero limits pin the output
        wait_for_drain();
        apply_settings(MODE_POSITION, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'd0, 15'd0);
        send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_STEP, 16'sd7, 16'sd0);
        wait_for_drain();
        apply_settings(MODE_POSITION, 16'sh8000, 16'sh7FFF, 16'sh8000, LIMIT_RESET, LIMIT_RESET);
        send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_STEP, -16'sd3, 16'sd4);
    endtask

    // no clear first: incremental mode picks up the positional output
    task automatic test_delta_directed();
        wait_for_drain();
        apply_settings(MODE_DELTA, 16'sh0100, 16'sh0020, 16'shFF80, 15'd1000, 15'd0);
        send_request(KIND_STEP, 16'sd10, 16'sd0);
        send_request(KIND_STEP, 16'sd20, 16'sd0);
        send_request(KIND_STEP, 16'sd20, 16'sd5);
        send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_STEP, 16'sd0, 16'sd0);
        send_request(KIND_CLEAR, 16'sd0, 16'sd0);
        send_request(KIND_STEP, 16'sd3, 16'sd1);
    endtask

    task automatic test_spare_index();
        wait_for_drain();
        cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));
        cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        repeat (4) send_request(KIND_STEP, rand_sample(), rand_sample());
    endtask

    // error sum driven far past the integral limit, then back through it
    task automatic test_integral_limit();
        wait_for_drain();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        apply_settings(MODE_POSITION, 16'sh0000, 16'sh0100, 16'sh0000, LIMIT_RESET, 15'd12000);
        send_request(KIND_CLEAR, 16'sd0, 16'sd0);
        repeat (16) send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        repeat (16) send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        send_request(KIND_CLEAR, 16'sd0, 16'sd0);
        repeat (8) send_request(KIND_STEP, 16'sh8000, 16'sh7FFF);
        repeat (4) send_request(KIND_STEP, 16'sh7FFF, 16'sh8000);
        wait_for_drain();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        src_gaps = 1'b0;
        apply_settings(MODE_DELTA, 16'sh0080, 16'sh0010, 16'sh0020, 15'd30000, 15'd30000);
        hold_off_req = 1'b1;
        repeat (24) send_request(KIND_STEP, rand_sample(), rand_sample());
        wait_for_drain();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int n_items;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_for_drain();
            src_gaps = (phase < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_gaps = (phase < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            apply_settings(1'($urandom), rand_gain(), rand_gain(), rand_gain(),
                           rand_limit(), rand_limit());
            n_items = $urandom_range(80, 110);
            for (int k = 0; k < n_items; k++)
            begin
                if (k == n_items / 2 && phase % 3 == 1)
                    wait_for_drain();
                if (k == 20 && phase == 2)
                    hold_off_req = 1'b1;
                send_request(($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_STEP,
                             rand_sample(), rand_sample());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_STEP;
        req_ch.target = '0;
        req_ch.measured = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_position_directed();
        test_delta_directed();
        test_spare_index();
        test_integral_limit();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
